// ===== src/mbsw_pkg.sv =====
package mbsw_pkg;

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HORIZ_RES    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERT_RES     = 2'd3;

    localparam int DIM_REG_W = 16;
    localparam int RES_REG_W = 31;
    localparam int CFG_DATA_W = 31;

    // bmp header
    localparam int HDR_LEN = 62;
    localparam int HDR_IDX_W = 6;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 6'(HDR_LEN - 1);
    localparam logic [15:0] BMP_MAGIC = 16'h4D42;
    localparam logic [31:0] BMP_DATA_OFFSET = 32'(14 + 40 + 8);
    localparam logic [31:0] BMP_DIB_SIZE = 32'd40;
    localparam logic [15:0] BMP_PLANES = 16'h0001;
    localparam logic [15:0] BMP_BPP = 16'h0001;
    localparam logic [31:0] BMP_PAL_BLACK = 32'h00000000;
    localparam logic [31:0] BMP_PAL_WHITE = 32'h00FFFFFF;

    // classified work passed from front to back
    typedef struct packed {
        logic       is_hdr;
        logic [7:0] data;
        logic [1:0] pads;
        logic       fdone;
    } t_job;

    // one byte of the output stream
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fdone;
    } t_obyte;

endpackage

// ===== src/mbsw_fifo.sv =====
module mbsw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wptr, r_rptr;
    logic [DEPTH_LOG2:0] r_count;
    logic wr_ok, rd_ok;

    assign o_full  = (r_count == (DEPTH_LOG2+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/mbsw_front.sv =====
module mbsw_front #(
    parameter int DIM_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_operation,
    input  logic                           i_pixel_bit,
    input  logic [mbsw_pkg::DIM_REG_W-1:0] i_width,
    input  logic [mbsw_pkg::DIM_REG_W-1:0] i_height,
    output logic                           o_job_wr,
    output mbsw_pkg::t_job                 o_job
);
    import mbsw_pkg::*;

    localparam int CW = (DIM_BITS > DIM_REG_W) ? DIM_BITS : DIM_REG_W;

    logic [7:0]          r_gather;
    logic [2:0]          r_count;
    logic [DIM_BITS-1:0] r_col;
    logic [DIM_BITS-1:0] r_row;
    logic [1:0]          r_phase;

    logic [7:0]          gather_nx;
    logic [DIM_BITS-1:0] col_nx, row_nx;
    logic [1:0]          phase_nx;
    logic                active, row_end, emit, is_start;

    always_comb begin
        gather_nx = r_gather;
        gather_nx[3'd7 - r_count] = r_gather[3'd7 - r_count] | i_pixel_bit;
    end

    assign is_start = (i_operation == OP_START);
    assign col_nx   = r_col + 1'b1;
    assign row_nx   = r_row + 1'b1;
    assign phase_nx = r_phase + 1'b1;
    assign active   = (i_width != '0) && (CW'(r_row) < CW'(i_height));
    assign row_end  = (CW'(col_nx) >= CW'(i_width));
    assign emit     = (r_count == 3'd7) || row_end;

    always_comb begin
        if (is_start) begin
            o_job.is_hdr = 1'b1;
            o_job.data   = 8'd0;
            o_job.pads   = 2'd0;
            o_job.fdone  = (i_width == '0) || (i_height == '0);
        end else begin
            o_job.is_hdr = 1'b0;
            o_job.data   = gather_nx;
            o_job.pads   = row_end ? (2'd0 - phase_nx) : 2'd0;
            o_job.fdone  = row_end && (CW'(row_nx) >= CW'(i_height));
        end
    end

    assign o_job_wr = i_accept && (is_start || (active && emit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_count  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_phase  <= '0;
        end else if (i_accept) begin
            if (is_start) begin
                r_gather <= '0;
                r_count  <= '0;
                r_col    <= '0;
                r_row    <= '0;
                r_phase  <= '0;
            end else if (active) begin
                r_gather <= emit ? 8'd0 : gather_nx;
                r_count  <= emit ? 3'd0 : (r_count + 1'b1);
                r_col    <= row_end ? '0 : col_nx;
                r_row    <= row_end ? row_nx : r_row;
                r_phase  <= row_end ? 2'd0 : (emit ? phase_nx : r_phase);
            end
        end
    end

endmodule

// ===== src/mbsw_back.sv =====
module mbsw_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbsw_pkg::t_job                 i_job,
    input  logic                           i_job_empty,
    output logic                           o_job_rd,
    input  logic [mbsw_pkg::DIM_REG_W-1:0] i_width,
    input  logic [mbsw_pkg::DIM_REG_W-1:0] i_height,
    input  logic [mbsw_pkg::RES_REG_W-1:0] i_horiz_res,
    input  logic [mbsw_pkg::RES_REG_W-1:0] i_vert_res,
    input  logic                           i_out_full,
    output logic                           o_out_wr,
    output mbsw_pkg::t_obyte               o_out
);
    import mbsw_pkg::*;

    localparam int WORDS_W = DIM_REG_W - 4;

    logic                 r_vld;
    t_job                 r_job;
    logic [HDR_IDX_W-1:0] r_idx;
    logic [31:0]          r_dsize;

    logic [DIM_REG_W:0]       w_sum;
    logic [WORDS_W-1:0]       row_words;
    logic [HDR_LEN*8-1:0]     hdr;
    logic [HDR_IDX_W-1:0]     last_idx;
    logic                     is_last, done, load;

    // image data size: height * 4-byte words per row
    assign w_sum     = (DIM_REG_W+1)'(i_width) + (DIM_REG_W+1)'(31);
    assign row_words = w_sum[DIM_REG_W:5];

    always_ff @(posedge i_clk) begin
        r_dsize <= {2'b00, 30'({i_height * 28'(row_words), 2'b00})};
    end

    // header image, byte 0 in the low bits
    assign hdr = {
        BMP_PAL_WHITE, BMP_PAL_BLACK, 32'd0, 32'd0,
        {1'b0, i_vert_res}, {1'b0, i_horiz_res}, r_dsize, 32'd0,
        BMP_BPP, BMP_PLANES, 32'(i_height), 32'(i_width),
        BMP_DIB_SIZE, BMP_DATA_OFFSET, 32'd0, r_dsize + 32'(HDR_LEN),
        BMP_MAGIC
    };

    assign last_idx = r_job.is_hdr ? HDR_LAST_IDX : HDR_IDX_W'(r_job.pads);
    assign is_last  = (r_idx == last_idx);
    assign o_out_wr = r_vld && !i_out_full;
    assign done     = o_out_wr && is_last;
    assign load     = (!r_vld || done) && !i_job_empty;
    assign o_job_rd = load;

    always_comb begin
        if (r_job.is_hdr) begin
            o_out.data = hdr[{r_idx, 3'b000} +: 8];
        end else begin
            o_out.data = (r_idx == '0) ? r_job.data : 8'd0;
        end
        o_out.last  = is_last;
        o_out.fdone = is_last && r_job.fdone;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (done) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (o_out_wr) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// ===== src/monochrome_bmp_stream_writer.sv =====
// path: a pixel's byte passes the job queue, the byte generator's job register and the
//   output queue; throughput: one request per cycle while full is low; the byte generator
//   makes one byte per cycle while the output queue has room, so a start request (62 header
//   bytes) or a row end with padding (up to 4 bytes) holds it busy and full rises once the
//   job queue between the two halves fills; reset: synchronous, active low; clears both
//   queues, the pixel/row counters and loads width 1, height 1, resolutions 0
module monochrome_bmp_stream_writer #(
    parameter int DIM_BITS = 16,
    parameter int JOBQ_DEPTH_LOG2 = 2,
    parameter int OUTQ_DEPTH_LOG2 = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            push,
    output logic                            full,
    input  logic                            i_operation,
    input  logic                            i_pixel_bit,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_run,
    output logic                            o_frame_done,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [mbsw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mbsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbsw_pkg::*;

    // width and height are used cut down to DIM_BITS bits
    localparam logic [DIM_REG_W-1:0] DIM_MASK = (DIM_BITS >= DIM_REG_W) ?
        {DIM_REG_W{1'b1}} : DIM_REG_W'((32'd1 << DIM_BITS) - 32'd1);

    // configuration registers
    logic [DIM_REG_W-1:0] r_width, r_height;
    logic [RES_REG_W-1:0] r_horiz_res, r_vert_res;
    logic [DIM_REG_W-1:0] width_m, height_m;

    // front to back job queue
    t_job   front_job, jobq_head;
    logic   jobq_wr, jobq_rd, jobq_empty;
    logic   accept;

    // byte stream into the output queue
    t_obyte back_byte, outq_head;
    logic   outq_wr, outq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_REG_W'(1);
            r_height    <= DIM_REG_W'(1);
            r_horiz_res <= '0;
            r_vert_res  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data[DIM_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data[DIM_REG_W-1:0];
                CFG_HORIZ_RES:    r_horiz_res <= i_cfg_data[RES_REG_W-1:0];
                CFG_VERT_RES:     r_vert_res  <= i_cfg_data[RES_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign width_m  = r_width & DIM_MASK;
    assign height_m = r_height & DIM_MASK;

    // a request is taken whenever the job queue has room, even one that makes no bytes
    assign accept = push && !full;

    // front: keeps pixel packing and row/column state, makes jobs for starts and finished bytes
    mbsw_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_pixel_bit (i_pixel_bit),
        .i_width     (width_m),
        .i_height    (height_m),
        .o_job_wr    (jobq_wr),
        .o_job       (front_job)
    );

    // short queue so the front keeps taking pixels while the back expands a burst
    mbsw_fifo #(
        .WIDTH      ($bits(t_job)),
        .DEPTH_LOG2 (JOBQ_DEPTH_LOG2)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (jobq_wr),
        .i_wdata (front_job),
        .i_rd    (jobq_rd),
        .o_rdata (jobq_head),
        .o_full  (full),
        .o_empty (jobq_empty)
    );

    // back: expands a job into header bytes or a data byte plus row padding
    mbsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (jobq_head),
        .i_job_empty (jobq_empty),
        .o_job_rd    (jobq_rd),
        .i_width     (width_m),
        .i_height    (height_m),
        .i_horiz_res (r_horiz_res),
        .i_vert_res  (r_vert_res),
        .i_out_full  (outq_full),
        .o_out_wr    (outq_wr),
        .o_out       (back_byte)
    );

    // output queue decouples the byte generator from the consumer
    mbsw_fifo #(
        .WIDTH      ($bits(t_obyte)),
        .DEPTH_LOG2 (OUTQ_DEPTH_LOG2)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (outq_wr),
        .i_wdata (back_byte),
        .i_rd    (pop),
        .o_rdata (outq_head),
        .o_full  (outq_full),
        .o_empty (empty)
    );

    assign o_out_byte    = outq_head.data;
    assign o_last_of_run = outq_head.last;
    assign o_frame_done  = outq_head.fdone;

endmodule
